[rtl/assert_macros.svh]
// Assertion helpers. Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/fct_pkg.sv]
package fct_pkg;

  localparam int unsigned TableDepthDef = 32;
  localparam logic [7:0]  ThrReset      = 8'd10;

  typedef enum logic [1:0] {
    ACT_SET     = 2'd0,
    ACT_CLR     = 2'd1,
    ACT_CLR_ALL = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LOOK = 2'd1,
    S_UPD  = 2'd2
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  code;
    logic [31:0] tick;
  } cmd_t;

  // Travels down the cell row; each cell ORs in its own contribution.
  typedef struct packed {
    logic        found;     // lookup match seen so far
    logic        sel;       // selected entry seen so far
    logic        old_pend;  // pending flag of selected entry before the update
    logic        pend;
    logic        conf;
    logic [7:0]  count;
    logic [31:0] first;
    logic [31:0] last;
  } chain_t;

endpackage

[rtl/fault_code_table.sv]
// Fault code table: one cell per entry in a row, lookups ripple down the row.
// An accepted beat is held in the command register, looked up in the lookup
// state and registered in the update state; the next beat may enter there.
// A stalled result holds the update cycle, and with it the next beat.
// Reset (async, active low) empties the table, zeroes the pending count and
// loads the confirm threshold with 10; entry contents are not cleared.
`include "assert_macros.svh"

module fault_code_table #(
  parameter int unsigned TABLE_DEPTH = fct_pkg::TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: confirm threshold
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // command channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  dtc_code_i,
  input  logic [31:0] tick_now_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic        table_full_o,
  output logic [4:0]  entry_index_o,
  output logic [7:0]  occurrence_count_o,
  output logic        pending_flag_o,
  output logic        confirmed_flag_o,
  output logic [31:0] first_tick_o,
  output logic [31:0] last_tick_o,
  output logic [5:0]  pending_count_o,
  output logic [5:0]  entry_count_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned UW = $clog2(TABLE_DEPTH + 1);

  fct_pkg::state_e state_q, state_d;
  fct_pkg::cmd_t   cmd_q;
  logic [7:0]      thr_q;
  logic [UW-1:0]   used_q, used_d;   // fill count: entries below it are live
  logic [UW-1:0]   pend_q, pend_d;   // running count of pending entries
  logic            hit_q, full_q;
  logic [IW-1:0]   idx_q;
  logic            out_valid_q;

  logic            in_acc, out_free, look_en, upd_en, append_go;
  fct_pkg::chain_t chain [TABLE_DEPTH+1];
  logic [IW-1:0]   idx_chain [TABLE_DEPTH+1];
  fct_pkg::chain_t res;
  logic            found;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------- cell row
  assign chain[0]     = '0;
  assign idx_chain[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    fct_cell #(
      .DEPTH (TABLE_DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd_q),
      .thr_i     (thr_q),
      .used_i    (used_q),
      .append_i  (append_go),
      .look_en_i (look_en),
      .upd_en_i  (upd_en),
      .chain_i   (chain[g]),
      .chain_o   (chain[g+1]),
      .idx_i     (idx_chain[g]),
      .idx_o     (idx_chain[g+1])
    );
  end

  assign res   = chain[TABLE_DEPTH];
  assign found = res.found;

  // unknown code on a set goes to the next free slot if there is one
  assign append_go = cmd_q.action == fct_pkg::ACT_SET && !found &&
                     used_q < UW'(TABLE_DEPTH);

  // ------------------------------------------------------------- control FSM
  always_comb begin
    state_d = state_q;
    case (state_q)
      fct_pkg::S_IDLE: if (in_acc) begin
        state_d = fct_pkg::S_LOOK;
      end
      fct_pkg::S_LOOK: begin
        state_d = fct_pkg::S_UPD;
      end
      fct_pkg::S_UPD: begin
        if (in_acc) begin
          state_d = fct_pkg::S_LOOK;
        end else if (out_free) begin
          state_d = fct_pkg::S_IDLE;
        end
      end
      default: state_d = fct_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    look_en    = 1'b0;
    upd_en     = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      fct_pkg::S_IDLE: in_stall_o = 1'b0;
      fct_pkg::S_LOOK: look_en    = 1'b1;
      fct_pkg::S_UPD: begin
        // update lands with the result; the next beat may enter alongside
        upd_en     = out_free;
        in_stall_o = !out_free;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------- fill / pending
  always_comb begin
    used_d = used_q;
    pend_d = pend_q;
    if (look_en) begin
      if (cmd_q.action == fct_pkg::ACT_CLR_ALL) begin
        used_d = '0;
        pend_d = '0;
      end else if (append_go) begin
        used_d = used_q + UW'(1);
      end
    end else if (upd_en) begin
      pend_d = pend_q + UW'(res.pend & ~res.old_pend) - UW'(res.old_pend & ~res.pend);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fct_pkg::S_IDLE;
      thr_q       <= fct_pkg::ThrReset;
      used_q      <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      pend_q  <= pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
      if (upd_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command and lookup-cycle payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= '{action: fct_pkg::action_e'(action_i), code: dtc_code_i, tick: tick_now_i};
    end
    if (look_en) begin
      hit_q  <= found | append_go;
      full_q <= cmd_q.action == fct_pkg::ACT_SET && !found && !append_go;
      idx_q  <= found ? idx_chain[TABLE_DEPTH] : IW'(used_q);
    end
  end

  // result register; unselected rows add only their match bit to the chain
  always_ff @(posedge clk_i) begin
    if (upd_en) begin
      hit_o              <= hit_q;
      table_full_o       <= full_q;
      entry_index_o      <= hit_q ? 5'(idx_q) : 5'd0;
      occurrence_count_o <= res.count;
      pending_flag_o     <= res.pend;
      confirmed_flag_o   <= res.conf;
      first_tick_o       <= res.first;
      last_tick_o        <= res.last;
      pending_count_o    <= 6'(pend_d);
      entry_count_o      <= 6'(used_q);
    end
  end

  assign out_valid_o = out_valid_q;

  // -------------------------------------------------------------- assertions
  `ASSERT_NEVER(a_pend_le_used, clk_i, rst_ni, pend_q > used_q, "pending count exceeds fill")
  `ASSERT_NEVER(a_used_le_depth, clk_i, rst_ni, used_q > UW'(TABLE_DEPTH), "fill count overflow")
  `ASSERT_NEVER(a_hit_full, clk_i, rst_ni, out_valid_o && hit_o && table_full_o, "hit and full")
  `ASSERT_PROP(a_sel_hit, clk_i, rst_ni, upd_en |-> (res.sel == hit_q), "selection mismatch")
  `ASSERT_PROP(a_upd_after_look, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == fct_pkg::S_UPD, "result outside update")

endmodule

[rtl/fct_cell.sv]
module fct_cell #(
  parameter int unsigned DEPTH = fct_pkg::TableDepthDef,
  parameter int unsigned IDX   = 0,
  localparam int unsigned IW   = $clog2(DEPTH),
  localparam int unsigned UW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fct_pkg::cmd_t    cmd_i,
  input  logic [7:0]       thr_i,
  input  logic [UW-1:0]    used_i,
  input  logic             append_i,
  input  logic             look_en_i,
  input  logic             upd_en_i,
  input  fct_pkg::chain_t  chain_i,
  output fct_pkg::chain_t  chain_o,
  input  logic [IW-1:0]    idx_i,
  output logic [IW-1:0]    idx_o
);

  logic [7:0]  code_q;
  logic [7:0]  cnt_q;
  logic [31:0] first_q, last_q;
  logic        pend_q, conf_q;
  logic        sel_q, new_q;

  logic            valid, match, pick_new;
  logic [7:0]      base_cnt, cnt_d;
  logic [31:0]     base_first, first_d, last_d;
  logic            base_conf, base_pend, pend_d, conf_d;
  fct_pkg::chain_t mine;

  assign valid    = UW'(IDX) < used_i;
  assign match    = valid && code_q == cmd_i.code &&
                    (cmd_i.action == fct_pkg::ACT_SET || cmd_i.action == fct_pkg::ACT_CLR);
  assign pick_new = append_i && used_i == UW'(IDX);

  // a freshly appended entry starts from an all-zero record
  assign base_cnt   = new_q ? 8'd0  : cnt_q;
  assign base_first = new_q ? 32'd0 : first_q;
  assign base_conf  = new_q ? 1'b0  : conf_q;
  assign base_pend  = new_q ? 1'b0  : pend_q;

  always_comb begin
    cnt_d   = base_cnt;
    first_d = base_first;
    last_d  = last_q;
    pend_d  = base_pend;
    conf_d  = base_conf;
    case (cmd_i.action)
      fct_pkg::ACT_SET: begin
        cnt_d   = base_cnt + 8'd1;
        last_d  = cmd_i.tick;
        first_d = (base_first == 32'd0) ? cmd_i.tick : base_first;
        pend_d  = 1'b1;
        conf_d  = base_conf | (cnt_d > thr_i);
      end
      fct_pkg::ACT_CLR: begin
        cnt_d  = 8'd0;
        pend_d = 1'b0;
        conf_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mine          = '0;
    mine.found    = match;
    mine.sel      = sel_q;
    mine.old_pend = sel_q & base_pend;
    if (sel_q) begin
      mine.pend  = pend_d;
      mine.conf  = conf_d;
      mine.count = cnt_d;
      mine.first = first_d;
      mine.last  = last_d;
    end
  end

  assign chain_o = chain_i | mine;
  assign idx_o   = idx_i | (match ? IW'(IDX) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
      new_q <= 1'b0;
    end else if (look_en_i) begin
      sel_q <= match | pick_new;
      new_q <= pick_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en_i && sel_q) begin
      code_q  <= cmd_i.code;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      last_q  <= last_d;
      pend_q  <= pend_d;
      conf_q  <= conf_d;
    end
  end

endmodule
